FILE: hw/rtl/bfms_pkg.sv
// shared types, constants and register codes of the bilinear fit and mask scaler
`timescale 1ns / 1ps

package bfms_pkg;

  localparam int SOURCE_PIXELS_DEF = 4096;
  localparam int MAX_DEST_SIDE_DEF = 256;
  localparam int MAX_SOURCE_SIDE   = 64;

  // quotient bits kept by the divider: enough for 63 whole pixels and 16 fraction bits
  localparam int QUO_W  = 23;
  localparam int NUM_W  = 17;
  localparam int DIV_W  = 10;
  localparam int PRE_W  = NUM_W - DIV_W;

  localparam logic [2:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_DEST_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_FIT_MODE      = 3'd4;
  localparam logic [2:0] CFG_MASK_SHAPE    = 3'd5;
  localparam logic [2:0] CFG_CORNER_RADIUS = 3'd6;

  localparam logic [1:0] SHAPE_RECT   = 2'd0;
  localparam logic [1:0] SHAPE_CIRCLE = 2'd1;
  localparam logic [1:0] SHAPE_ROUND  = 2'd2;

  // saturated geometry; the user must keep it static while any item is in flight, the block does not enforce it
  typedef struct packed {
    logic [6:0] sw;
    logic [6:0] sh;
    logic [8:0] dw;
    logic [8:0] dh;
    logic       fit;
    logic [1:0] shape;
    logic [8:0] m;
    logic [8:0] r;
  } geo_t;

  typedef struct packed {
    logic        query;
    logic        cov;
    logic [11:0] lidx;
    logic [31:0] lrgba;
  } pay_t;

  typedef struct packed {
    pay_t             pay;
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    logic [DIV_W-1:0] vd;
  } div_in_t;

  typedef struct packed {
    pay_t             pay;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic             ovx;
    logic             ovy;
  } div_out_t;

endpackage

FILE: hw/rtl/bfms_front.sv
// geometry stages: scale pick, image and mask tests, source coordinate numerators
`timescale 1ns / 1ps

module bfms_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bfms_pkg::geo_t    geo,
  input  logic              in_v,
  input  logic              in_func,
  input  logic [11:0]       in_lidx,
  input  logic [31:0]       in_lrgba,
  input  logic [7:0]        in_x,
  input  logic [7:0]        in_y,
  output logic              out_v,
  output bfms_pkg::div_in_t out_d
);
  import bfms_pkg::*;

  typedef struct packed {
    pay_t        pay;
    logic        inbox;
    logic [8:0]  px;
    logic [8:0]  py;
    logic [15:0] pw;
    logic [15:0] ph;
  } s1_t;

  typedef struct packed {
    pay_t               pay;
    logic               inbox;
    logic [8:0]         n;
    logic [15:0]        dpx;
    logic [15:0]        dpy;
    logic [15:0]        ddw;
    logic [15:0]        ddh;
    logic [15:0]        swn;
    logic [15:0]        shn;
    logic signed [16:0] nxa;
    logic signed [16:0] nya;
    logic [14:0]        nxb;
    logic [14:0]        nyb;
    logic signed [10:0] mdx;
    logic signed [10:0] mdy;
    logic [8:0]         lim;
    logic               maskall;
  } s2_t;

  typedef struct packed {
    pay_t               pay;
    logic               inbox;
    logic               inimg;
    logic [18:0]        sq;
    logic [17:0]        lim2;
    logic               maskall;
    logic signed [17:0] numx;
    logic signed [17:0] numy;
    logic [8:0]         n;
  } s3_t;

  s1_t     s1_r, s1_nxt;
  s2_t     s2_r, s2_nxt;
  s3_t     s3_r, s3_nxt;
  div_in_t s4_r, s4_nxt;
  logic    v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    s1_nxt.pay.query = in_func;
    s1_nxt.pay.cov   = 1'b0;
    s1_nxt.pay.lidx  = in_lidx;
    s1_nxt.pay.lrgba = in_lrgba;
    s1_nxt.inbox     = ({1'b0, in_x} < geo.dw) && ({1'b0, in_y} < geo.dh);
    s1_nxt.px        = {in_x, 1'b1};
    s1_nxt.py        = {in_y, 1'b1};
    s1_nxt.pw        = 16'(geo.dw) * 16'(geo.sh);
    s1_nxt.ph        = 16'(geo.dh) * 16'(geo.sw);
  end

  // stage 2: pick the scale ratio, then the products that depend on it and the mask offsets
  logic       pick_x;
  logic [8:0] n_c;
  logic [6:0] d_c;
  logic [9:0] hix, hiy, cx, cy;

  always_comb begin
    if (geo.fit) begin
      pick_x = s1_r.pw >= s1_r.ph;
    end else begin
      pick_x = s1_r.pw <= s1_r.ph;
    end
    n_c = pick_x ? geo.dw : geo.dh;
    d_c = pick_x ? geo.sw : geo.sh;

    hix = {geo.dw, 1'b0} - 10'(geo.r);
    hiy = {geo.dh, 1'b0} - 10'(geo.r);
    if ({1'b0, s1_r.px} < 10'(geo.r)) begin
      cx = 10'(geo.r);
    end else if ({1'b0, s1_r.px} > hix) begin
      cx = hix;
    end else begin
      cx = {1'b0, s1_r.px};
    end
    if ({1'b0, s1_r.py} < 10'(geo.r)) begin
      cy = 10'(geo.r);
    end else if ({1'b0, s1_r.py} > hiy) begin
      cy = hiy;
    end else begin
      cy = {1'b0, s1_r.py};
    end

    s2_nxt.pay   = s1_r.pay;
    s2_nxt.inbox = s1_r.inbox;
    s2_nxt.n     = n_c;
    s2_nxt.dpx   = 16'(d_c) * 16'(s1_r.px);
    s2_nxt.dpy   = 16'(d_c) * 16'(s1_r.py);
    s2_nxt.ddw   = 16'(d_c) * 16'(geo.dw);
    s2_nxt.ddh   = 16'(d_c) * 16'(geo.dh);
    s2_nxt.swn   = 16'(geo.sw) * 16'(n_c);
    s2_nxt.shn   = 16'(geo.sh) * 16'(n_c);
    s2_nxt.nxa   = 17'($signed({2'b0, s1_r.px}) - $signed({2'b0, geo.dw}))
                 * 17'($signed({1'b0, d_c}));
    s2_nxt.nya   = 17'($signed({2'b0, s1_r.py}) - $signed({2'b0, geo.dh}))
                 * 17'($signed({1'b0, d_c}));
    s2_nxt.nxb   = 15'(geo.sw - 7'd1) * 15'(n_c);
    s2_nxt.nyb   = 15'(geo.sh - 7'd1) * 15'(n_c);
    s2_nxt.maskall = 1'b0;
    case (geo.shape)
      SHAPE_CIRCLE: begin
        s2_nxt.mdx = $signed({2'b0, s1_r.px}) - $signed({2'b0, geo.dw});
        s2_nxt.mdy = $signed({2'b0, s1_r.py}) - $signed({2'b0, geo.dh});
        s2_nxt.lim = geo.m;
      end
      SHAPE_ROUND: begin
        s2_nxt.mdx = $signed({2'b0, s1_r.px}) - $signed({1'b0, cx});
        s2_nxt.mdy = $signed({2'b0, s1_r.py}) - $signed({1'b0, cy});
        s2_nxt.lim = geo.r;
      end
      default: begin
        // rectangle and the unused code: no mask
        s2_nxt.mdx     = '0;
        s2_nxt.mdy     = '0;
        s2_nxt.lim     = '0;
        s2_nxt.maskall = 1'b1;
      end
    endcase
  end

  // stage 3: image bounds, squared distances, numerator sums
  logic signed [21:0] sqx, sqy;

  always_comb begin
    sqx = 22'(s2_r.mdx) * 22'(s2_r.mdx);
    sqy = 22'(s2_r.mdy) * 22'(s2_r.mdy);
    s3_nxt.pay     = s2_r.pay;
    s3_nxt.inbox   = s2_r.inbox;
    s3_nxt.inimg   = !((17'(s2_r.dpx) + 17'(s2_r.swn)) < 17'(s2_r.ddw))
                  && !(17'(s2_r.dpx) >= (17'(s2_r.ddw) + 17'(s2_r.swn)))
                  && !((17'(s2_r.dpy) + 17'(s2_r.shn)) < 17'(s2_r.ddh))
                  && !(17'(s2_r.dpy) >= (17'(s2_r.ddh) + 17'(s2_r.shn)));
    s3_nxt.sq      = sqx[18:0] + sqy[18:0];
    s3_nxt.lim2    = 18'(s2_r.lim) * 18'(s2_r.lim);
    s3_nxt.maskall = s2_r.maskall;
    s3_nxt.numx    = 18'(s2_r.nxa) + $signed({3'b0, s2_r.nxb});
    s3_nxt.numy    = 18'(s2_r.nya) + $signed({3'b0, s2_r.nyb});
    s3_nxt.n       = s2_r.n;
  end

  // stage 4: cover flag and clamped numerators for the divider
  always_comb begin
    s4_nxt.pay     = s3_r.pay;
    s4_nxt.pay.cov = s3_r.inbox && s3_r.inimg
                  && (s3_r.maskall || (s3_r.sq <= {1'b0, s3_r.lim2}));
    s4_nxt.nx      = s3_r.numx[17] ? '0 : s3_r.numx[NUM_W-1:0];
    s4_nxt.ny      = s3_r.numy[17] ? '0 : s3_r.numy[NUM_W-1:0];
    s4_nxt.vd      = {s3_r.n, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign out_v = v4_r;
  assign out_d = s4_r;

endmodule

FILE: hw/rtl/bfms_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y in lockstep
`timescale 1ns / 1ps

module bfms_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  bfms_pkg::div_in_t  in_d,
  output logic               out_v,
  output bfms_pkg::div_out_t out_d
);
  import bfms_pkg::*;

  typedef struct packed {
    pay_t             pay;
    logic [DIV_W-1:0] vd;
    logic [DIV_W-1:0] remx;
    logic [DIV_W-1:0] remy;
    logic [PRE_W-1:0] bitsx;
    logic [PRE_W-1:0] bitsy;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic             ovx;
    logic             ovy;
  } dst_t;

  dst_t st_r   [QUO_W+1];
  dst_t st_nxt [QUO_W+1];
  logic v_r    [QUO_W+1];

  // head stage: overflow means the quotient exceeds the clamp anyway
  always_comb begin
    st_nxt[0].pay   = in_d.pay;
    st_nxt[0].vd    = in_d.vd;
    st_nxt[0].remx  = in_d.nx[NUM_W-1:PRE_W];
    st_nxt[0].remy  = in_d.ny[NUM_W-1:PRE_W];
    st_nxt[0].bitsx = in_d.nx[PRE_W-1:0];
    st_nxt[0].bitsy = in_d.ny[PRE_W-1:0];
    st_nxt[0].qx    = '0;
    st_nxt[0].qy    = '0;
    st_nxt[0].ovx   = in_d.nx >= {in_d.vd, {PRE_W{1'b0}}};
    st_nxt[0].ovy   = in_d.ny >= {in_d.vd, {PRE_W{1'b0}}};
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [DIV_W:0] tx, ty;
    logic           gex, gey;
    always_comb begin
      tx  = {st_r[i].remx, st_r[i].bitsx[PRE_W-1]};
      ty  = {st_r[i].remy, st_r[i].bitsy[PRE_W-1]};
      gex = tx >= {1'b0, st_r[i].vd};
      gey = ty >= {1'b0, st_r[i].vd};
      st_nxt[i+1]       = st_r[i];
      st_nxt[i+1].remx  = gex ? DIV_W'(tx - {1'b0, st_r[i].vd}) : tx[DIV_W-1:0];
      st_nxt[i+1].remy  = gey ? DIV_W'(ty - {1'b0, st_r[i].vd}) : ty[DIV_W-1:0];
      st_nxt[i+1].bitsx = {st_r[i].bitsx[PRE_W-2:0], 1'b0};
      st_nxt[i+1].bitsy = {st_r[i].bitsy[PRE_W-2:0], 1'b0};
      st_nxt[i+1].qx    = {st_r[i].qx[QUO_W-2:0], gex};
      st_nxt[i+1].qy    = {st_r[i].qy[QUO_W-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QUO_W; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 1; i <= QUO_W; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= QUO_W; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_v     = v_r[QUO_W];
  assign out_d.pay = st_r[QUO_W].pay;
  assign out_d.qx  = st_r[QUO_W].qx;
  assign out_d.qy  = st_r[QUO_W].qy;
  assign out_d.ovx = st_r[QUO_W].ovx;
  assign out_d.ovy = st_r[QUO_W].ovy;

endmodule

FILE: hw/rtl/bfms_interp.sv
// source store, neighbour fetch and bilinear blend stages ending in the output register
`timescale 1ns / 1ps

module bfms_interp #(
  parameter int SOURCE_PIXELS = bfms_pkg::SOURCE_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  bfms_pkg::geo_t     geo,
  input  logic               in_v,
  input  bfms_pkg::div_out_t in_d,
  output logic               out_v,
  output logic [31:0]        out_pix,
  output logic               out_cov
);
  import bfms_pkg::*;

  localparam int AW = (SOURCE_PIXELS > 1) ? $clog2(SOURCE_PIXELS) : 1;

  typedef struct packed {
    pay_t       pay;
    logic [5:0] x0;
    logic [5:0] x1;
    logic [5:0] y0;
    logic [5:0] y1;
    logic [7:0] fx;
    logic [7:0] fy;
  } c1_t;

  typedef struct packed {
    pay_t        pay;
    logic [11:0] i00;
    logic [11:0] i10;
    logic [11:0] i01;
    logic [11:0] i11;
    logic [7:0]  fx;
    logic [7:0]  fy;
  } c2_t;

  c1_t  c1_r, c1_nxt;
  c2_t  c2_r, c2_nxt;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [31:0] mem_a [SOURCE_PIXELS];
  logic [31:0] mem_b [SOURCE_PIXELS];

  logic [31:0] rd00_r, rd10_r, rd01_r, rd11_r;
  logic [3:0]  ok_r, ok_nxt;
  logic [7:0]  fx3_r, fy3_r, fy4_r;
  logic        cov3_r, cov4_r;
  logic [15:0] top_r [4];
  logic [15:0] bot_r [4];
  logic [15:0] top_nxt [4];
  logic [15:0] bot_nxt [4];
  logic [31:0] pix_r, pix_nxt;
  logic        cov5_r;

  // stage 1: clamp coordinates, split whole and fraction parts
  logic [21:0] limx, limy, sx, sy;
  always_comb begin
    limx = {6'(geo.sw - 7'd1), 16'b0};
    limy = {6'(geo.sh - 7'd1), 16'b0};
    sx   = (in_d.ovx || in_d.qx > QUO_W'(limx)) ? limx : in_d.qx[21:0];
    sy   = (in_d.ovy || in_d.qy > QUO_W'(limy)) ? limy : in_d.qy[21:0];
    c1_nxt.pay = in_d.pay;
    c1_nxt.x0  = sx[21:16];
    c1_nxt.y0  = sy[21:16];
    c1_nxt.fx  = sx[15:8];
    c1_nxt.fy  = sy[15:8];
    c1_nxt.x1  = ((7'(sx[21:16]) + 7'd1) < geo.sw) ? 6'(sx[21:16] + 6'd1)
                                                   : 6'(geo.sw - 7'd1);
    c1_nxt.y1  = ((7'(sy[21:16]) + 7'd1) < geo.sh) ? 6'(sy[21:16] + 6'd1)
                                                   : 6'(geo.sh - 7'd1);
  end

  // stage 2: linear store positions
  always_comb begin
    c2_nxt.pay = c1_r.pay;
    c2_nxt.i00 = 12'(c1_r.y0) * 12'(geo.sw) + 12'(c1_r.x0);
    c2_nxt.i10 = 12'(c1_r.y0) * 12'(geo.sw) + 12'(c1_r.x1);
    c2_nxt.i01 = 12'(c1_r.y1) * 12'(geo.sw) + 12'(c1_r.x0);
    c2_nxt.i11 = 12'(c1_r.y1) * 12'(geo.sw) + 12'(c1_r.x1);
    c2_nxt.fx  = c1_r.fx;
    c2_nxt.fy  = c1_r.fy;
  end

  // stage 3: store access; loads write here so queries behind them see the data
  logic wr_en;
  always_comb begin
    wr_en  = en && v2_r && !c2_r.pay.query
          && ({20'b0, c2_r.pay.lidx} < 32'(SOURCE_PIXELS));
    ok_nxt = {({20'b0, c2_r.i11} < 32'(SOURCE_PIXELS)),
              ({20'b0, c2_r.i01} < 32'(SOURCE_PIXELS)),
              ({20'b0, c2_r.i10} < 32'(SOURCE_PIXELS)),
              ({20'b0, c2_r.i00} < 32'(SOURCE_PIXELS))};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[AW'(c2_r.pay.lidx)] <= c2_r.pay.lrgba;
      mem_b[AW'(c2_r.pay.lidx)] <= c2_r.pay.lrgba;
    end
    if (en) begin
      rd00_r <= mem_a[AW'(c2_r.i00)];
      rd10_r <= mem_a[AW'(c2_r.i10)];
      rd01_r <= mem_b[AW'(c2_r.i01)];
      rd11_r <= mem_b[AW'(c2_r.i11)];
    end
  end

  // stage 4: horizontal blend per channel
  logic [31:0] p00, p10, p01, p11;
  logic [8:0]  wfx;
  always_comb begin
    p00 = ok_r[0] ? rd00_r : '0;
    p10 = ok_r[1] ? rd10_r : '0;
    p01 = ok_r[2] ? rd01_r : '0;
    p11 = ok_r[3] ? rd11_r : '0;
    wfx = 9'd256 - 9'(fx3_r);
    for (int c = 0; c < 4; c++) begin
      top_nxt[c] = 16'(p00[8*c +: 8]) * 16'(wfx) + 16'(p10[8*c +: 8]) * 16'(fx3_r);
      bot_nxt[c] = 16'(p01[8*c +: 8]) * 16'(wfx) + 16'(p11[8*c +: 8]) * 16'(fx3_r);
    end
  end

  // stage 5: vertical blend, round to nearest, zero where the pixel is not covered
  logic [8:0]  wfy;
  logic [23:0] vs [4];
  always_comb begin
    wfy = 9'd256 - 9'(fy4_r);
    for (int c = 0; c < 4; c++) begin
      vs[c] = 24'(top_r[c]) * 24'(wfy) + 24'(bot_r[c]) * 24'(fy4_r) + 24'd32768;
      pix_nxt[8*c +: 8] = cov4_r ? vs[c][23:16] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r && c2_r.pay.query;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      ok_r   <= ok_nxt;
      fx3_r  <= c2_r.fx;
      fy3_r  <= c2_r.fy;
      cov3_r <= c2_r.pay.cov;
      fy4_r  <= fy3_r;
      cov4_r <= cov3_r;
      for (int c = 0; c < 4; c++) begin
        top_r[c] <= top_nxt[c];
        bot_r[c] <= bot_nxt[c];
      end
      pix_r  <= pix_nxt;
      cov5_r <= cov4_r;
    end
  end

  assign out_v   = v5_r;
  assign out_pix = pix_r;
  assign out_cov = cov5_r;

endmodule

FILE: hw/rtl/bilinear_fit_mask_scaler_core.sv
// top level: configuration registers, stall control and the three pipeline sections
`timescale 1ns / 1ps

// Bilinear scaler with contain/cover fit and a shape mask.
// Input stream: in_tuser[0] selects the beat kind, 0 loads one source pixel into the
// store, 1 queries one destination pixel. Loads give no result; each query gives one
// result beat on the output stream, in order.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register; write only
// while no beat is in flight.
// Pipeline: a query passes 4 geometry stages, 24 divider stages and 5 fetch and
// blend stages. One beat is taken per cycle while the output is not stalled, set by
// the one-bit-per-stage divider pipeline and the dual copy of the store.
// A load whose index lies inside the store is written to it as it passes the fetch
// stage, so a query accepted after such a load always sees it.
// Reset clears the valid bits and restores the register defaults; the store holds
// whatever it held and must be loaded before use.
// When out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.

module bilinear_fit_mask_scaler_core #(
  parameter int SOURCE_PIXELS = bfms_pkg::SOURCE_PIXELS_DEF,
  parameter int MAX_DEST_SIDE = bfms_pkg::MAX_DEST_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // load_index[11:0], load_rgba, out_x, out_y, zero pad
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_rgba
  output logic [0:0]  out_tuser,  // covered
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);
  import bfms_pkg::*;

  logic [6:0] sw_r, sh_r;
  logic [8:0] dw_r, dh_r, crh_r;
  logic       fit_r;
  logic [1:0] shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= 7'd64;
      sh_r    <= 7'd64;
      dw_r    <= 9'd64;
      dh_r    <= 9'd64;
      fit_r   <= 1'b0;
      shape_r <= SHAPE_RECT;
      crh_r   <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  sw_r    <= cfg_wdata[6:0];
        CFG_SOURCE_HEIGHT: sh_r    <= cfg_wdata[6:0];
        CFG_DEST_WIDTH:    dw_r    <= cfg_wdata;
        CFG_DEST_HEIGHT:   dh_r    <= cfg_wdata;
        CFG_FIT_MODE:      fit_r   <= cfg_wdata[0];
        CFG_MASK_SHAPE:    shape_r <= cfg_wdata[1:0];
        CFG_CORNER_RADIUS: crh_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate sizes into their legal ranges
  geo_t geo;
  always_comb begin
    if (sw_r == 7'd0) begin
      geo.sw = 7'd1;
    end else if (32'(sw_r) > MAX_SOURCE_SIDE) begin
      geo.sw = 7'(MAX_SOURCE_SIDE);
    end else begin
      geo.sw = sw_r;
    end
    if (sh_r == 7'd0) begin
      geo.sh = 7'd1;
    end else if (32'(sh_r) > MAX_SOURCE_SIDE) begin
      geo.sh = 7'(MAX_SOURCE_SIDE);
    end else begin
      geo.sh = sh_r;
    end
    if (dw_r == 9'd0) begin
      geo.dw = 9'd1;
    end else if (32'(dw_r) > MAX_DEST_SIDE) begin
      geo.dw = 9'(MAX_DEST_SIDE);
    end else begin
      geo.dw = dw_r;
    end
    if (dh_r == 9'd0) begin
      geo.dh = 9'd1;
    end else if (32'(dh_r) > MAX_DEST_SIDE) begin
      geo.dh = 9'(MAX_DEST_SIDE);
    end else begin
      geo.dh = dh_r;
    end
    geo.fit   = fit_r;
    geo.shape = shape_r;
    geo.m     = (geo.dw < geo.dh) ? geo.dw : geo.dh;
    geo.r     = (crh_r > geo.m) ? geo.m : crh_r;
  end

  // one enable for every stage: hold all while a result waits untaken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic     fr_v, dv_v;
  div_in_t  fr_d;
  div_out_t dv_d;

  bfms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .geo      (geo),
    .in_v     (in_tvalid),
    .in_func  (in_tuser[0]),
    .in_lidx  (in_tdata[11:0]),
    .in_lrgba (in_tdata[43:12]),
    .in_x     (in_tdata[51:44]),
    .in_y     (in_tdata[59:52]),
    .out_v    (fr_v),
    .out_d    (fr_d)
  );

  bfms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (fr_v),
    .in_d  (fr_d),
    .out_v (dv_v),
    .out_d (dv_d)
  );

  bfms_interp #(
    .SOURCE_PIXELS (SOURCE_PIXELS)
  ) u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .geo     (geo),
    .in_v    (dv_v),
    .in_d    (dv_d),
    .out_v   (out_tvalid),
    .out_pix (out_tdata),
    .out_cov (out_tuser[0])
  );

endmodule
